>>> hdl/cbs_pkg.sv
// cbs_pkg: shared types and constants for the cubic Bezier sampler.
// Used by cbs_datapath, cbs_ctrl and cubic_bezier_sampler_top.
`timescale 1ns / 1ps
`default_nettype none
package cbs_pkg;

  localparam int T_IN_W   = 17;  // t_start / t_end field width
  localparam int CNT_W    = 6;   // sample_count and point_index width
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_START_X  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_START_Y  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_END_X    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_END_Y    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CTRL_A_X = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_CTRL_A_Y = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_CTRL_B_X = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_CTRL_B_Y = 3'd7;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_SUBDIV = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_TCALC, ST_DIV, ST_LERP, ST_COPY, ST_SUB2, ST_EMIT_S, ST_EMIT_Q
  } state_t;

  typedef enum logic [1:0] {
    OUT_X5, OUT_Q, OUT_ERR
  } out_src_t;

  typedef struct packed {
    logic             load_req;
    logic             div_start;
    logic             div_sub;     // 1: subdivision ratio, 0: sample step
    logic             t_from_div;
    logic             t_from_ts;
    logic             lerp_en;
    logic [2:0]       lerp_step;
    logic             copy_right;
    logic             copy_left;
    logic             out_load;
    out_src_t         out_src;
    logic [1:0]       out_k;
    logic [CNT_W-1:0] idx;         // point counter, also sample multiplier
    logic             out_last;
  } cmd_t;

  typedef struct packed {
    logic             req;
    logic             n_zero;
    logic [CNT_W-1:0] n;
    logic             range_bad;
    logic             ts_zero;
    logic             te_one;
    logic             div_done;
    logic             out_free;
  } status_t;

endpackage
`default_nettype wire

>>> hdl/cbs_div.sv
// cbs_div: iterative restoring divider, one quotient bit per cycle.
// Standalone; used by cbs_datapath.
`timescale 1ns / 1ps
`default_nettype none
module cbs_div #(
  parameter int NW = 34,
  parameter int DW = 17
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               done,
  output logic [NW-1:0]      quot
);
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] num_r, num_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, done_r, done_nxt;
  logic [DW+1:0] trial;

  always_comb begin
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, num_r[NW-1]} - {2'b00, den_r};
    if (start && !busy_r) begin
      num_nxt  = num;
      rem_nxt  = '0;
      den_nxt  = den;
      cnt_nxt  = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[DW+1]) begin
        rem_nxt = trial[DW:0];
        num_nxt = {num_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[DW-1:0], num_r[NW-1]};
        num_nxt = {num_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quot = num_r;
endmodule
`default_nettype wire

>>> hdl/cbs_datapath.sv
// cbs_datapath: control point registers, parameter math, shared lerp unit
// and output register. Depends on cbs_pkg and cbs_div.
`timescale 1ns / 1ps
`default_nettype none
module cbs_datapath #(
  parameter int MAX_SAMPLES = 63,
  parameter int COORD_WIDTH = 24,
  parameter int T_FRAC_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [cbs_pkg::REG_IDX_W-1:0] cfg_index,
  input  wire logic [COORD_WIDTH-1:0]       cfg_wdata,
  input  wire logic                         req_type,
  input  wire logic [cbs_pkg::T_IN_W-1:0]   t_start,
  input  wire logic [cbs_pkg::T_IN_W-1:0]   t_end,
  input  wire logic [cbs_pkg::CNT_W-1:0]    sample_count,
  input  wire cbs_pkg::cmd_t                cmd,
  output cbs_pkg::status_t                  sts,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [COORD_WIDTH-1:0]            out_x,
  output logic [COORD_WIDTH-1:0]            out_y,
  output logic [cbs_pkg::CNT_W-1:0]         out_index,
  output logic                              out_status,
  output logic                              out_last
);
  import cbs_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int F  = T_FRAC_BITS;
  localparam int TW = F + 1;
  localparam int NW = 2 * F + 2;
  localparam int XW = T_IN_W + TW;
  localparam logic [TW-1:0] T_ONE = TW'(1) << F;

  // control points from configuration
  logic signed [CW-1:0] cx_r [4];
  logic signed [CW-1:0] cy_r [4];
  // working curve and intermediates x0..x5
  logic signed [CW-1:0] qx_r [4];
  logic signed [CW-1:0] qy_r [4];
  logic signed [CW-1:0] ix_r [6];
  logic signed [CW-1:0] iy_r [6];

  logic          req_r;
  logic [TW-1:0] ts_r, te_r, t_r;
  logic [CNT_W-1:0] n_r;

  logic [TW-1:0] ts_c, te_c;
  logic [CNT_W-1:0] n_c;

  always_comb begin
    ts_c = (XW'(t_start) > XW'(T_ONE)) ? T_ONE : TW'(t_start);
    te_c = (XW'(t_end) > XW'(T_ONE)) ? T_ONE : TW'(t_end);
    n_c  = (9'(sample_count) > 9'(MAX_SAMPLES)) ? CNT_W'(MAX_SAMPLES) : sample_count;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 4; k++) begin
        cx_r[k] <= '0;
        cy_r[k] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_X:  cx_r[0] <= cfg_wdata;
        REG_START_Y:  cy_r[0] <= cfg_wdata;
        REG_CTRL_A_X: cx_r[1] <= cfg_wdata;
        REG_CTRL_A_Y: cy_r[1] <= cfg_wdata;
        REG_CTRL_B_X: cx_r[2] <= cfg_wdata;
        REG_CTRL_B_Y: cy_r[2] <= cfg_wdata;
        REG_END_X:    cx_r[3] <= cfg_wdata;
        REG_END_Y:    cy_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // parameter difference and divider operands
  logic signed [TW:0] d;
  logic [TW-1:0]      d_abs;
  logic [NW-1:0]      div_num;
  logic [TW-1:0]      div_den;
  logic               div_done;
  logic [NW-1:0]      div_q;

  always_comb begin
    d     = $signed({1'b0, te_r}) - $signed({1'b0, ts_r});
    d_abs = d[TW] ? TW'(-d) : TW'(d);
    if (cmd.div_sub) begin
      div_num = NW'(d_abs) << F;
      div_den = T_ONE - ts_r;
    end else begin
      div_num = NW'(d_abs) * NW'(cmd.idx);
      div_den = TW'(n_r);
    end
  end

  cbs_div #(.NW(NW), .DW(TW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_q)
  );

  // lerp operand select per step of the de Casteljau triangle
  logic signed [CW-1:0] ax, ay, bx, by;
  always_comb begin
    case (cmd.lerp_step)
      3'd0: begin ax = qx_r[0]; ay = qy_r[0]; bx = qx_r[1]; by = qy_r[1]; end
      3'd1: begin ax = qx_r[1]; ay = qy_r[1]; bx = qx_r[2]; by = qy_r[2]; end
      3'd2: begin ax = qx_r[2]; ay = qy_r[2]; bx = qx_r[3]; by = qy_r[3]; end
      3'd3: begin ax = ix_r[0]; ay = iy_r[0]; bx = ix_r[1]; by = iy_r[1]; end
      3'd4: begin ax = ix_r[1]; ay = iy_r[1]; bx = ix_r[2]; by = iy_r[2]; end
      3'd5: begin ax = ix_r[3]; ay = iy_r[3]; bx = ix_r[4]; by = iy_r[4]; end
      default: begin ax = ix_r[3]; ay = iy_r[3]; bx = ix_r[4]; by = iy_r[4]; end
    endcase
  end

  logic signed [CW:0]      dx, dy;
  logic signed [CW+TW+1:0] px, py;
  logic signed [CW+TW+1:0] sx, sy;
  logic signed [CW-1:0]    lx, ly;
  always_comb begin
    dx = $signed({bx[CW-1], bx}) - $signed({ax[CW-1], ax});
    dy = $signed({by[CW-1], by}) - $signed({ay[CW-1], ay});
    px = dx * $signed({1'b0, t_r});
    py = dy * $signed({1'b0, t_r});
    sx = px >>> F;  // floor
    sy = py >>> F;
    lx = ax + sx[CW-1:0];
    ly = ay + sy[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r <= req_type;
      ts_r  <= ts_c;
      te_r  <= te_c;
      n_r   <= n_c;
      for (int k = 0; k < 4; k++) begin
        qx_r[k] <= cx_r[k];
        qy_r[k] <= cy_r[k];
      end
    end else if (cmd.copy_right) begin
      qx_r[0] <= ix_r[5]; qy_r[0] <= iy_r[5];
      qx_r[1] <= ix_r[4]; qy_r[1] <= iy_r[4];
      qx_r[2] <= ix_r[2]; qy_r[2] <= iy_r[2];
    end else if (cmd.copy_left) begin
      qx_r[1] <= ix_r[0]; qy_r[1] <= iy_r[0];
      qx_r[2] <= ix_r[3]; qy_r[2] <= iy_r[3];
      qx_r[3] <= ix_r[5]; qy_r[3] <= iy_r[5];
    end
    if (cmd.t_from_ts) begin
      t_r <= ts_r;
    end else if (cmd.t_from_div) begin
      if (cmd.div_sub) t_r <= div_q[TW-1:0];
      else if (d[TW]) t_r <= ts_r - div_q[TW-1:0];
      else t_r <= ts_r + div_q[TW-1:0];
    end
    if (cmd.lerp_en) begin
      ix_r[cmd.lerp_step] <= lx;
      iy_r[cmd.lerp_step] <= ly;
    end
  end

  // output register
  logic out_valid_r;
  logic [CW-1:0] ox_r, oy_r;
  logic [CNT_W-1:0] oi_r;
  logic os_r, ol_r;
  logic out_free;
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.out_load) begin
      oi_r <= cmd.idx;
      ol_r <= cmd.out_last;
      case (cmd.out_src)
        OUT_X5: begin ox_r <= ix_r[5]; oy_r <= iy_r[5]; os_r <= 1'b0; end
        OUT_Q: begin ox_r <= qx_r[cmd.out_k]; oy_r <= qy_r[cmd.out_k]; os_r <= 1'b0; end
        default: begin ox_r <= '0; oy_r <= '0; os_r <= 1'b1; end
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_x      = ox_r;
  assign out_y      = oy_r;
  assign out_index  = oi_r;
  assign out_status = os_r;
  assign out_last   = ol_r;

  always_comb begin
    sts.req       = req_r;
    sts.n_zero    = (n_r == '0);
    sts.n         = n_r;
    sts.range_bad = (ts_r >= te_r);
    sts.ts_zero   = (ts_r == '0);
    sts.te_one    = (te_r == T_ONE);
    sts.div_done  = div_done;
    sts.out_free  = out_free;
  end
endmodule
`default_nettype wire

>>> hdl/cbs_ctrl.sv
// cbs_ctrl: request sequencer issuing commands to cbs_datapath.
// Depends on cbs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cbs_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire cbs_pkg::status_t sts,
  output cbs_pkg::cmd_t         cmd
);
  import cbs_pkg::*;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] i_r, i_nxt;
  logic [2:0] step_r, step_nxt;
  logic [1:0] k_r, k_nxt;
  logic phase_r, phase_nxt;   // 0: first split at t_start, 1: second split

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      step_r  <= '0;
      k_r     <= '0;
      phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      step_r  <= step_nxt;
      k_r     <= k_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    step_nxt  = step_r;
    k_nxt     = k_r;
    phase_nxt = phase_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.out_src   = OUT_X5;
    cmd.idx       = i_r;
    cmd.lerp_step = step_r;
    cmd.out_k     = k_r;
    cmd.div_sub   = phase_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          i_nxt     = '0;
          step_nxt  = '0;
          k_nxt     = '0;
          phase_nxt = 1'b0;
          state_nxt = ST_TCALC;
        end
      end
      ST_TCALC: begin
        if (sts.req == REQ_SAMPLE) begin
          if (sts.n_zero) begin
            cmd.t_from_ts = 1'b1;
            state_nxt = ST_LERP;
          end else begin
            cmd.div_start = 1'b1;
            state_nxt = ST_DIV;
          end
        end else if (sts.range_bad) begin
          if (sts.out_free) begin
            cmd.out_load = 1'b1;
            cmd.out_src  = OUT_ERR;
            cmd.idx      = '0;
            cmd.out_last = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else if (sts.ts_zero) begin
          state_nxt = ST_SUB2;
        end else begin
          cmd.t_from_ts = 1'b1;
          state_nxt = ST_LERP;
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          cmd.t_from_div = 1'b1;
          state_nxt = ST_LERP;
        end
      end
      ST_LERP: begin
        cmd.lerp_en = 1'b1;
        if (step_r == 3'd5) begin
          step_nxt  = '0;
          state_nxt = (sts.req == REQ_SAMPLE) ? ST_EMIT_S : ST_COPY;
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end
      ST_COPY: begin
        if (phase_r) begin
          cmd.copy_left = 1'b1;
          state_nxt = ST_EMIT_Q;
        end else begin
          cmd.copy_right = 1'b1;
          state_nxt = ST_SUB2;
        end
      end
      ST_SUB2: begin
        if (sts.te_one) begin
          state_nxt = ST_EMIT_Q;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sub   = 1'b1;
          phase_nxt = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_EMIT_S: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_src  = OUT_X5;
          cmd.out_last = (i_r == sts.n);
          if (i_r == sts.n) begin
            state_nxt = ST_IDLE;
          end else begin
            i_nxt = i_r + 1'b1;
            state_nxt = ST_TCALC;
          end
        end
      end
      ST_EMIT_Q: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_src  = OUT_Q;
          cmd.idx      = CNT_W'(k_r);
          cmd.out_last = (k_r == 2'd3);
          k_nxt = k_r + 2'd1;
          if (k_r == 2'd3) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

>>> hdl/cubic_bezier_sampler_top.sv
// cubic_bezier_sampler_top: cubic Bezier flattening and subdivision block.
// Depends on cbs_pkg, cbs_ctrl, cbs_datapath, cbs_div.
//
// Usage: write the four control points through cfg_* while idle, then send
// requests on in_*. in_tuser is req_type: 0 samples sample_count+1 points
// from t_start toward t_end, 1 emits the four points of the sub-curve over
// [t_start, t_end], or one error result (status 1) when t_start >= t_end.
// Results leave on out_* with out_tlast on the last point of a request.
// One request is processed at a time; in_tready is high only when idle.
// Each sampled point uses the bit-serial divider for the step parameter,
// then six lerps on the shared lerp unit; with a count of 0 the divider is
// skipped for the single point. A subdivision without error ends by
// emitting its four points. The output register lets the next point be
// computed while the previous one waits; when the receiver stalls, the
// sequencer holds until the output register is free, and nothing is
// dropped. Synchronous reset clears the control points to zero, empties
// the output register and returns the sequencer to idle.
`timescale 1ns / 1ps
`default_nettype none
module cubic_bezier_sampler_top #(
  parameter int MAX_SAMPLES = 63,
  parameter int COORD_WIDTH = 24,
  parameter int T_FRAC_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [cbs_pkg::REG_IDX_W-1:0] cfg_index,
  input  wire logic [COORD_WIDTH-1:0]        cfg_wdata,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // t_start[16:0], t_end[33:17], sample_count[39:34]
  input  wire logic [39:0]                   in_tdata,
  // req_type
  input  wire logic                          in_tuser,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // x, y, point_index, status, zero fill
  output logic [((2*COORD_WIDTH+14)/8)*8-1:0] out_tdata,
  output logic                               out_tlast
);
  import cbs_pkg::*;

  localparam int OW = ((2 * COORD_WIDTH + 14) / 8) * 8;

  cmd_t    cmd;
  status_t sts;
  logic [COORD_WIDTH-1:0] ox, oy;
  logic [CNT_W-1:0] oi;
  logic os;

  cbs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cbs_datapath #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .COORD_WIDTH (COORD_WIDTH),
    .T_FRAC_BITS (T_FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .req_type     (in_tuser),
    .t_start      (in_tdata[16:0]),
    .t_end        (in_tdata[33:17]),
    .sample_count (in_tdata[39:34]),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_x        (ox),
    .out_y        (oy),
    .out_index    (oi),
    .out_status   (os),
    .out_last     (out_tlast)
  );

  assign out_tdata = OW'({os, oi, oy, ox});
endmodule
`default_nettype wire
